FILE: hw/rtl/fvn_pkg.sv
// fvn_pkg: types, constants and hash helpers for the fractal value noise block
// no dependencies; imported by fvn_octave_cell and fractal_value_noise
`timescale 1ns / 1ps

package fvn_pkg;

  localparam int NOISE_W = 24;
  localparam int CNT_W   = 4;
  localparam int COORD_W = 48;

  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [NOISE_W-1:0] noise_t;
  typedef logic [COORD_W-1:0] coord_t;

  // scaled coordinate pair, bits 47..16 are the cell, 15..0 the fraction
  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  localparam cnt_t        CNT_RESET = 4'd4;
  localparam logic [31:0] HASH_KX   = 32'd73856093;
  localparam logic [31:0] HASH_KY   = 32'd19349663;
  localparam logic [31:0] MIX_XOR   = 32'd61;
  localparam logic [31:0] MIX_MUL   = 32'h27d4eb2d;
  localparam logic [17:0] EASE_K    = 18'd196608;
  localparam logic [24:0] ONE_Q24   = 25'h1000000;
  localparam logic [48:0] HALF_Q24  = 49'h800000;

  // first part of the integer mix, up to and including the multiply by nine
  function automatic logic [31:0] mix_a(input logic [31:0] h);
    logic [31:0] a;
    a = h ^ MIX_XOR;
    a = a ^ (a >> 16);
    return a + (a << 3);
  endfunction

  function automatic logic [31:0] mix_b(input logic [31:0] h);
    logic [31:0] a;
    a = h ^ (h >> 4);
    return a * MIX_MUL;
  endfunction

  function automatic logic [31:0] mix_c(input logic [31:0] h);
    return h ^ (h >> 15);
  endfunction

endpackage

FILE: hw/rtl/fvn_octave_cell.sv
// fvn_octave_cell: one octave of value noise as a seven-stage pipeline
// hands the doubled coordinate to the next cell in the cycle after it arrives, adds into the running sum
// depends on fvn_pkg
`timescale 1ns / 1ps

module fvn_octave_cell #(
  parameter int MAX_OCTAVES = 8,
  parameter int IDX         = 0
) (
  input  logic                                         clk,
  input  fvn_pkg::cnt_t                                octave_count,
  input  fvn_pkg::point_t                              pt_in,
  output fvn_pkg::point_t                              pt_out,
  input  logic [fvn_pkg::NOISE_W+MAX_OCTAVES-1:0]      acc_in,
  output logic [fvn_pkg::NOISE_W+MAX_OCTAVES-1:0]      acc_out
);

  import fvn_pkg::*;

  localparam int   ACC_W = NOISE_W + MAX_OCTAVES;
  localparam int   SHIFT = MAX_OCTAVES - 1 - IDX;
  localparam cnt_t IDX_C = CNT_W'(IDX);

  // stage 1
  logic [31:0] px0, py0, txx, tyy;
  logic [15:0] tx, ty;
  logic [31:0] px0_c, py0_c, txx_c, tyy_c;
  // stage 2
  logic [3:0][31:0] h9, h9_c;
  logic [49:0] ex, ey, ex_c, ey_c;
  logic [31:0] px1, py1;
  logic [17:0] ux, uy;
  // stage 3
  logic [3:0][31:0] hm, hm_c;
  logic [24:0] wx3, wy3, wx_c, wy_c;
  logic [49:0] wx_sum, wy_sum;
  // stage 4
  logic [3:0][31:0] hf;
  logic [3:0][48:0] pr, pr_c;
  logic [24:0] wy4, wxi;
  // stage 5
  logic [23:0] top, bot;
  logic [48:0] top_sum, bot_sum;
  logic [24:0] wy5;
  // stage 6
  logic [48:0] qa, qb, qa_c, qb_c;
  logic [24:0] wyi;
  // stage 7
  logic [48:0] o_sum;
  logic [23:0] o_val;
  logic [ACC_W-1:0] add_val;

  always_comb begin
    px0_c = pt_in.x[47:16] * HASH_KX;
    py0_c = pt_in.y[47:16] * HASH_KY;
    txx_c = {16'b0, pt_in.x[15:0]} * {16'b0, pt_in.x[15:0]};
    tyy_c = {16'b0, pt_in.y[15:0]} * {16'b0, pt_in.y[15:0]};
  end

  // neighbouring cells: (cx+1)*k is cx*k + k
  always_comb begin
    px1 = px0 + HASH_KX;
    py1 = py0 + HASH_KY;
    h9_c[0] = mix_a(px0 ^ py0);
    h9_c[1] = mix_a(px1 ^ py0);
    h9_c[2] = mix_a(px0 ^ py1);
    h9_c[3] = mix_a(px1 ^ py1);
    ux = EASE_K - {1'b0, tx, 1'b0};
    uy = EASE_K - {1'b0, ty, 1'b0};
    ex_c = 50'(txx) * 50'(ux);
    ey_c = 50'(tyy) * 50'(uy);
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      hm_c[k] = mix_b(h9[k]);
    end
    wx_sum = ex + 50'(HALF_Q24);
    wy_sum = ey + 50'(HALF_Q24);
    wx_c   = wx_sum[48:24];
    wy_c   = wy_sum[48:24];
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      hf[k] = mix_c(hm[k]);
    end
    wxi     = ONE_Q24 - wx3;
    pr_c[0] = 49'(hf[0][23:0]) * 49'(wxi);
    pr_c[1] = 49'(hf[1][23:0]) * 49'(wx3);
    pr_c[2] = 49'(hf[2][23:0]) * 49'(wxi);
    pr_c[3] = 49'(hf[3][23:0]) * 49'(wx3);
  end

  always_comb begin
    top_sum = pr[0] + pr[1] + HALF_Q24;
    bot_sum = pr[2] + pr[3] + HALF_Q24;
  end

  always_comb begin
    wyi  = ONE_Q24 - wy5;
    qa_c = 49'(top) * 49'(wyi);
    qb_c = 49'(bot) * 49'(wy5);
  end

  // octave weight is a shift of the exact sum
  always_comb begin
    o_sum   = qa + qb + HALF_Q24;
    o_val   = o_sum[47:24];
    add_val = (octave_count > IDX_C) ? (ACC_W'(o_val) << SHIFT) : '0;
  end

  always_ff @(posedge clk) begin
    px0      <= px0_c;
    py0      <= py0_c;
    txx      <= txx_c;
    tyy      <= tyy_c;
    tx       <= pt_in.x[15:0];
    ty       <= pt_in.y[15:0];
    pt_out.x <= {pt_in.x[COORD_W-2:0], 1'b0};
    pt_out.y <= {pt_in.y[COORD_W-2:0], 1'b0};
    h9       <= h9_c;
    ex       <= ex_c;
    ey       <= ey_c;
    hm       <= hm_c;
    wx3      <= wx_c;
    wy3      <= wy_c;
    pr       <= pr_c;
    wy4      <= wy3;
    top      <= top_sum[47:24];
    bot      <= bot_sum[47:24];
    wy5      <= wy4;
    qa       <= qa_c;
    qb       <= qb_c;
    acc_out  <= acc_in + add_val;
  end

endmodule

FILE: hw/rtl/fractal_value_noise.sv
// the done strobe marks each accepted word once its result is in the output register;
// throughput is one word per cycle out of reset, start may stay high
// the result passes the row of octave cells, one per octave, each a seven-stage pipeline
// whose running sum moves from cell to cell in step with the coordinate hand-off
// reset: synchronous, active high; octave_count returns to 4, pending results are dropped,
// busy is high during reset and for the cycle after it
`timescale 1ns / 1ps

module fractal_value_noise #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [31:0]    coord_x,
  input  logic signed [31:0]    coord_y,
  output logic                  done,
  output fvn_pkg::noise_t       noise_value,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  fvn_pkg::cnt_t         cfg_data
);

  import fvn_pkg::*;

  localparam int ACC_W = NOISE_W + MAX_OCTAVES;
  localparam int VLD_N = MAX_OCTAVES + 8;
  localparam logic [ACC_W:0] RND = (ACC_W + 1)'(1) << (MAX_OCTAVES - 1);

  cnt_t             octave_count;
  point_t           pt0;
  logic [VLD_N-1:0] vld;
  logic [VLD_N-1:0] vld_next;
  point_t           pt_link [MAX_OCTAVES];
  logic [ACC_W-1:0] acc_i   [MAX_OCTAVES];
  logic [ACC_W-1:0] acc_o   [MAX_OCTAVES];
  logic [ACC_W:0]   rnd_sum;
  logic             accept;

  assign accept    = start && !busy;
  assign cfg_ready = !busy;
  assign done      = vld[VLD_N-1];

  always_comb begin
    vld_next = {vld[VLD_N-2:0], accept};
    rnd_sum  = (ACC_W + 1)'(acc_o[MAX_OCTAVES-1]) + RND;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b1;
      vld          <= '0;
      octave_count <= CNT_RESET;
    end else begin
      busy <= 1'b0;
      vld  <= vld_next;
      if (cfg_valid && cfg_ready) begin
        octave_count <= cfg_data;
      end
    end
  end

  // payload registers, marked by the valid line alone
  always_ff @(posedge clk) begin
    pt0.x <= {{(COORD_W - 32){coord_x[31]}}, coord_x};
    pt0.y <= {{(COORD_W - 32){coord_y[31]}}, coord_y};
    noise_value <= rnd_sum[ACC_W] ? '1 : rnd_sum[ACC_W-1:MAX_OCTAVES];
  end

  for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign acc_i[g]   = '0;
      assign pt_link[g] = pt0;
    end else begin : g_rest
      assign acc_i[g] = acc_o[g-1];
    end

    if (g < MAX_OCTAVES - 1) begin : g_link
      fvn_octave_cell #(
        .MAX_OCTAVES (MAX_OCTAVES),
        .IDX         (g)
      ) u_cell (
        .clk          (clk),
        .octave_count (octave_count),
        .pt_in        (pt_link[g]),
        .pt_out       (pt_link[g+1]),
        .acc_in       (acc_i[g]),
        .acc_out      (acc_o[g])
      );
    end else begin : g_end
      fvn_octave_cell #(
        .MAX_OCTAVES (MAX_OCTAVES),
        .IDX         (g)
      ) u_cell (
        .clk          (clk),
        .octave_count (octave_count),
        .pt_in        (pt_link[g]),
        .pt_out       (),
        .acc_in       (acc_i[g]),
        .acc_out      (acc_o[g])
      );
    end
  end

endmodule

FILE: hw/rtl/fvn_checker.sv
// fvn_checker: port-level checks on the fractal value noise block, bound to the top level
// depends on fractal_value_noise
`timescale 1ns / 1ps

module fvn_checker #(
  parameter int MAX_OCTAVES = 8
) (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic cfg_ready
);

  localparam int LAT = MAX_OCTAVES + 8;

  // out of reset the block takes a word and a config write every cycle
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> !busy && cfg_ready)
    else $error("busy or cfg_ready wrong after reset");

  // every accepted word gives exactly one strobe
  a_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT done)
    else $error("accepted word gave no result");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result strobe without an accepted word");

endmodule

bind fractal_value_noise fvn_checker #(
  .MAX_OCTAVES (MAX_OCTAVES)
) u_fvn_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .cfg_ready (cfg_ready)
);
